// ===== hdl/multi_segment_envelope_generator_assert.svh =====
// Assertion macros used by the envelope generator sequencer (mseg_ctrl).
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef MULTI_SEGMENT_ENVELOPE_GENERATOR_ASSERT_SVH
`define MULTI_SEGMENT_ENVELOPE_GENERATOR_ASSERT_SVH

// same-cycle implication
`define MSEG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSEG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mseg_pkg.sv =====
// Shared types, codes and helper functions for the envelope generator.
// No dependencies; used by mseg_ctrl, mseg_dp and the top level.
package mseg_pkg;

    localparam int DEF_VOICES   = 32;
    localparam int DEF_SEGMENTS = 4;

    localparam logic signed [23:0] Q_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] Q_MIN = 24'sh800000;
    localparam logic signed [23:0] Q_ONE = 24'sh400000;

    // item modes
    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_START = 3'd1;
    localparam logic [2:0] MODE_STOP  = 3'd2;
    localparam logic [2:0] MODE_RATE  = 3'd3;
    localparam logic [2:0] MODE_DEST  = 3'd4;

    // rendering kinds
    localparam logic [2:0] KIND_IDLE    = 3'd0;
    localparam logic [2:0] KIND_LINEAR  = 3'd1;
    localparam logic [2:0] KIND_DECAY   = 3'd2;
    localparam logic [2:0] KIND_CURVED  = 3'd3;
    localparam logic [2:0] KIND_RELEASE = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_KINDS = 3'd0;
    localparam logic [2:0] CFG_LINKS = 3'd1;
    localparam logic [2:0] CFG_START = 3'd2;
    localparam logic [2:0] CFG_STOP  = 3'd3;
    localparam logic [2:0] CFG_FLOOR = 3'd4;

    // multiplier operand selections
    localparam logic [2:0] MUL_NONE     = 3'd0;
    localparam logic [2:0] MUL_DIFF_X   = 3'd1;
    localparam logic [2:0] MUL_DIFF_CV  = 3'd2;
    localparam logic [2:0] MUL_DIFF_1MY = 3'd3;
    localparam logic [2:0] MUL_Y_1MR    = 3'd4;
    localparam logic [2:0] MUL_HARD_LVL = 3'd5;
    localparam logic [2:0] MUL_C_AM     = 3'd6;
    localparam logic [2:0] MUL_CV_U     = 3'd7;

    // datapath register actions
    localparam logic [3:0] ACT_NONE      = 4'd0;
    localparam logic [3:0] ACT_LOAD      = 4'd1;
    localparam logic [3:0] ACT_WRMEM     = 4'd2;
    localparam logic [3:0] ACT_LIN_DONE  = 4'd3;
    localparam logic [3:0] ACT_LIN_END   = 4'd4;
    localparam logic [3:0] ACT_SETTLE    = 4'd5;
    localparam logic [3:0] ACT_DEC_LVL   = 4'd6;
    localparam logic [3:0] ACT_DEC_Y     = 4'd7;
    localparam logic [3:0] ACT_CURV_INIT = 4'd8;
    localparam logic [3:0] ACT_CURV_U    = 4'd9;
    localparam logic [3:0] ACT_CURV_V    = 4'd10;
    localparam logic [3:0] ACT_CURV_DONE = 4'd11;
    localparam logic [3:0] ACT_STOP      = 4'd12;
    localparam logic [3:0] ACT_START     = 4'd13;
    localparam logic [3:0] ACT_ENT_SET   = 4'd14;
    localparam logic [3:0] ACT_COMMIT    = 4'd15;

    typedef struct packed {
        logic [2:0]         mode;
        logic [4:0]         voice;
        logic [2:0]         segment;
        logic signed [23:0] value;
        logic signed [23:0] attack_curve;
        logic [22:0]        retrigger_hardness;
    } t_in;

    typedef struct packed {
        logic [4:0]         voice_out;
        logic signed [23:0] signal;
        logic [2:0]         segment_now;
        logic               idle;
    } t_out;

    typedef struct packed {
        logic       take;
        logic       clr;
        logic       rd_enter;
        logic [2:0] mul;
        logic [3:0] act;
    } t_cmd;

    typedef struct packed {
        logic [2:0] mode;
        logic       v_ok;
        logic [2:0] kind;
        logic       x_lt_one;
        logic       y_gt_floor;
        logic       clr_done;
        logic       out_free;
    } t_sts;

    // clip to signed 24 bits
    function automatic logic signed [23:0] sat24(input logic signed [33:0] v);
        if (v > 34'(Q_MAX)) begin
            return Q_MAX;
        end else if (v < 34'(Q_MIN)) begin
            return Q_MIN;
        end
        return v[23:0];
    endfunction

    // kind of a segment; unknown codes and out-of-range segments are idle
    function automatic logic [2:0] kind_of(input logic [11:0] kinds, input logic [2:0] s,
                                           input int segs);
        logic [2:0] k;
        k = KIND_IDLE;
        if (int'(s) <= segs) begin
            unique case (s)
                3'd1:    k = kinds[2:0];
                3'd2:    k = kinds[5:3];
                3'd3:    k = kinds[8:6];
                3'd4:    k = kinds[11:9];
                default: k = KIND_IDLE;
            endcase
        end
        return (k > KIND_RELEASE) ? KIND_IDLE : k;
    endfunction

    // following segment; out of range links go to idle
    function automatic logic [2:0] link_of(input logic [11:0] links, input logic [2:0] s,
                                           input int segs);
        logic [2:0] l;
        l = 3'd0;
        if (int'(s) <= segs) begin
            unique case (s)
                3'd1:    l = links[2:0];
                3'd2:    l = links[5:3];
                3'd3:    l = links[8:6];
                3'd4:    l = links[11:9];
                default: l = 3'd0;
            endcase
        end
        return (int'(l) > segs) ? 3'd0 : l;
    endfunction

endpackage

// ===== hdl/multi_segment_envelope_generator.sv =====
// Polyphonic multi-segment envelope generator, top level.
// Depends on mseg_pkg, mseg_ctrl and mseg_dp.
//
// One transaction in, one result out, one transaction at a time. After
// reset every entry of the rate and destination memories is cleared
// before the first transaction is taken; configuration writes are taken
// throughout. Writes, unused modes, out-of-range voices, idle ticks and
// settled decay ticks go from dispatch straight to commit; stop, start,
// segment advances and settled release ticks also read the entry of the
// next segment. Curved attack ticks run the eight chained curve products
// one after the other on the single shared 27x27 multiplier. A finished
// result waits in an output register and the next transaction is taken
// meanwhile; a result still held there when the next one is ready stalls
// that transaction until the receiver takes it.
module multi_segment_envelope_generator #(
    parameter int VOICES   = mseg_pkg::DEF_VOICES,
    parameter int SEGMENTS = mseg_pkg::DEF_SEGMENTS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  mseg_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output mseg_pkg::t_out o_data,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [22:0]    i_cfg_data
);

    mseg_pkg::t_cmd cmd;
    mseg_pkg::t_sts sts;

    // sequencer
    mseg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // datapath
    mseg_dp #(
        .VOICES   (VOICES),
        .SEGMENTS (SEGMENTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_data     (i_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data)
    );

endmodule

// ===== hdl/mseg_ctrl.sv =====
// Sequencer for the envelope generator: walks each transaction through
// the datapath steps. Depends on mseg_pkg and the assertion macro header.
`include "multi_segment_envelope_generator_assert.svh"

module mseg_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  mseg_pkg::t_sts i_sts,
    output mseg_pkg::t_cmd o_cmd
);

    localparam logic [4:0] S_CLEAR  = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_LOAD   = 5'd2;
    localparam logic [4:0] S_DISP   = 5'd3;
    localparam logic [4:0] S_LIND   = 5'd4;
    localparam logic [4:0] S_DEC1   = 5'd5;
    localparam logic [4:0] S_DEC2   = 5'd6;
    localparam logic [4:0] S_CM1    = 5'd7;
    localparam logic [4:0] S_CU     = 5'd8;
    localparam logic [4:0] S_CM2    = 5'd9;
    localparam logic [4:0] S_CV     = 5'd10;
    localparam logic [4:0] S_CFM    = 5'd11;
    localparam logic [4:0] S_CFD    = 5'd12;
    localparam logic [4:0] S_STM    = 5'd13;
    localparam logic [4:0] S_ENTRD  = 5'd14;
    localparam logic [4:0] S_ENTSET = 5'd15;
    localparam logic [4:0] S_COMMIT = 5'd16;

    logic [4:0] r_state, n_state;
    logic [1:0] r_cnt, n_cnt;

    // state and curve step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    // next state and commands
    always_comb begin
        n_state         = r_state;
        n_cnt           = r_cnt;
        o_cmd.take      = 1'b0;
        o_cmd.clr       = 1'b0;
        o_cmd.rd_enter  = 1'b0;
        o_cmd.mul       = mseg_pkg::MUL_NONE;
        o_cmd.act       = mseg_pkg::ACT_NONE;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.act = mseg_pkg::ACT_LOAD;
                n_state   = S_DISP;
            end
            S_DISP: begin
                n_state = S_COMMIT;
                if (i_sts.v_ok) begin
                    unique case (i_sts.mode)
                        mseg_pkg::MODE_TICK: begin
                            unique case (i_sts.kind)
                                mseg_pkg::KIND_LINEAR: begin
                                    if (i_sts.x_lt_one) begin
                                        o_cmd.mul = mseg_pkg::MUL_DIFF_X;
                                        n_state   = S_LIND;
                                    end else begin
                                        o_cmd.act = mseg_pkg::ACT_LIN_END;
                                        n_state   = S_ENTRD;
                                    end
                                end
                                mseg_pkg::KIND_CURVED: begin
                                    if (i_sts.x_lt_one) begin
                                        o_cmd.act = mseg_pkg::ACT_CURV_INIT;
                                        n_cnt     = 2'd0;
                                        n_state   = S_CM1;
                                    end else begin
                                        o_cmd.act = mseg_pkg::ACT_LIN_END;
                                        n_state   = S_ENTRD;
                                    end
                                end
                                mseg_pkg::KIND_DECAY, mseg_pkg::KIND_RELEASE: begin
                                    if (i_sts.y_gt_floor) begin
                                        o_cmd.mul = mseg_pkg::MUL_DIFF_1MY;
                                        n_state   = S_DEC1;
                                    end else begin
                                        o_cmd.act = mseg_pkg::ACT_SETTLE;
                                        if (i_sts.kind == mseg_pkg::KIND_RELEASE) begin
                                            n_state = S_ENTRD;
                                        end
                                    end
                                end
                                default: n_state = S_COMMIT;
                            endcase
                        end
                        mseg_pkg::MODE_START: begin
                            o_cmd.mul = mseg_pkg::MUL_HARD_LVL;
                            n_state   = S_STM;
                        end
                        mseg_pkg::MODE_STOP: begin
                            o_cmd.act = mseg_pkg::ACT_STOP;
                            n_state   = S_ENTRD;
                        end
                        mseg_pkg::MODE_RATE, mseg_pkg::MODE_DEST: begin
                            o_cmd.act = mseg_pkg::ACT_WRMEM;
                        end
                        default: n_state = S_COMMIT;
                    endcase
                end
            end
            S_LIND: begin
                o_cmd.act = mseg_pkg::ACT_LIN_DONE;
                n_state   = S_COMMIT;
            end
            S_DEC1: begin
                o_cmd.act = mseg_pkg::ACT_DEC_LVL;
                o_cmd.mul = mseg_pkg::MUL_Y_1MR;
                n_state   = S_DEC2;
            end
            S_DEC2: begin
                o_cmd.act = mseg_pkg::ACT_DEC_Y;
                n_state   = S_COMMIT;
            end
            S_CM1: begin
                o_cmd.mul = mseg_pkg::MUL_C_AM;
                n_state   = S_CU;
            end
            S_CU: begin
                o_cmd.act = mseg_pkg::ACT_CURV_U;
                n_state   = S_CM2;
            end
            S_CM2: begin
                o_cmd.mul = mseg_pkg::MUL_CV_U;
                n_state   = S_CV;
            end
            S_CV: begin
                o_cmd.act = mseg_pkg::ACT_CURV_V;
                n_cnt     = r_cnt + 2'd1;
                n_state   = (r_cnt == 2'd3) ? S_CFM : S_CM1;
            end
            S_CFM: begin
                o_cmd.mul = mseg_pkg::MUL_DIFF_CV;
                n_state   = S_CFD;
            end
            S_CFD: begin
                o_cmd.act = mseg_pkg::ACT_CURV_DONE;
                n_state   = S_COMMIT;
            end
            S_STM: begin
                o_cmd.act = mseg_pkg::ACT_START;
                n_state   = S_ENTRD;
            end
            S_ENTRD: begin
                o_cmd.rd_enter = 1'b1;
                n_state        = S_ENTSET;
            end
            S_ENTSET: begin
                o_cmd.act = mseg_pkg::ACT_ENT_SET;
                n_state   = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.act = mseg_pkg::ACT_COMMIT;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `MSEG_ASSERT_NEXT(a_take_loads, (r_state == S_IDLE) && i_valid, r_state == S_LOAD, "accepted transaction not loaded")
    `MSEG_ASSERT_NEXT(a_commit_waits, (r_state == S_COMMIT) && !i_sts.out_free, r_state == S_COMMIT, "result dropped while output full")
    `MSEG_ASSERT_NEXT(a_curve_four, (r_state == S_CV) && (r_cnt == 2'd3), r_state == S_CFM, "curve did not finish after four steps")
    `MSEG_ASSERT_NOW(a_clear_no_take, r_state == S_CLEAR, o_stall && !o_cmd.take, "transaction taken during clear")

endmodule

// ===== hdl/mseg_dp.sv =====
// Datapath: configuration, per-voice state, rate/destination memories,
// shared Q1.22 multiplier and output register. Depends on mseg_pkg.
module mseg_dp #(
    parameter int VOICES   = mseg_pkg::DEF_VOICES,
    parameter int SEGMENTS = mseg_pkg::DEF_SEGMENTS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [22:0]    i_cfg_data,
    input  mseg_pkg::t_in  i_data,
    input  mseg_pkg::t_cmd i_cmd,
    output mseg_pkg::t_sts o_sts,
    output logic           o_valid,
    input  logic           i_stall,
    output mseg_pkg::t_out o_data
);

    localparam int SLOTS = SEGMENTS + 1;
    localparam int DEPTH = VOICES * SLOTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam logic signed [26:0] ONE27 = 27'(mseg_pkg::Q_ONE);

    // configuration
    logic [11:0] r_kinds, r_links;
    logic [2:0]  r_start_seg, r_stop_seg;
    logic [22:0] r_floor;

    // per-voice state
    logic signed [23:0] r_px [VOICES];
    logic signed [23:0] r_fy [VOICES];
    logic signed [23:0] r_sl [VOICES];
    logic signed [23:0] r_lv [VOICES];
    logic [2:0]         r_kn [VOICES];
    logic [2:0]         r_si [VOICES];
    logic [2:0]         r_sf [VOICES];
    logic signed [23:0] r_curve;

    // rate and destination memories
    logic signed [23:0] rate_mem [DEPTH];
    logic signed [23:0] dest_mem [DEPTH];
    logic signed [23:0] r_rate, r_dest;
    logic [AW-1:0]      r_clr;

    // working registers for the transaction in flight
    mseg_pkg::t_in      r_item;
    logic signed [23:0] r_x, r_y, r_st, r_lvl, r_cv, r_ent_st;
    logic [2:0]         r_kind, r_seg, r_fol, r_ent_seg;
    logic signed [26:0] r_u;
    logic signed [31:0] r_prod;

    logic               r_ovalid;
    mseg_pkg::t_out     r_out;

    logic [6:0]         vfull;
    logic               v_ok;
    logic [VW-1:0]      vi;
    logic [2:0]         rd_seg;
    logic [AW-1:0]      raddr, waddr;
    logic               we_rate, we_dest;
    logic signed [23:0] wdata;
    logic signed [26:0] diff, cv_abs, op_a, op_b;
    logic signed [53:0] prod;
    logic signed [33:0] st34;
    logic signed [23:0] lvl_prod, lvl_dest, x_next;
    logic               out_free;

    function automatic logic [AW-1:0] slot_addr(input logic [VW-1:0] v, input logic [2:0] s);
        logic [AW+3:0] t;
        t = (AW+4)'(v) * (AW+4)'(SLOTS) + (AW+4)'(s);
        return t[AW-1:0];
    endfunction

    function automatic logic [2:0] clamp_seg(input logic [2:0] s);
        return (int'(s) > SEGMENTS) ? 3'd0 : s;
    endfunction

    // voice decode
    assign vfull = 7'(r_item.voice);
    assign v_ok  = vfull < 7'(VOICES);
    assign vi    = vfull[VW-1:0];

    // memory addressing
    assign rd_seg  = i_cmd.rd_enter ? r_ent_seg : r_si[vi];
    assign raddr   = slot_addr(vi, rd_seg);
    assign waddr   = i_cmd.clr ? r_clr : slot_addr(vi, r_item.segment);
    assign wdata   = i_cmd.clr ? '0 : r_item.value;
    assign we_rate = i_cmd.clr || ((i_cmd.act == mseg_pkg::ACT_WRMEM) && v_ok
                     && (r_item.mode == mseg_pkg::MODE_RATE)
                     && (int'(r_item.segment) <= SEGMENTS));
    assign we_dest = i_cmd.clr || ((i_cmd.act == mseg_pkg::ACT_WRMEM) && v_ok
                     && (r_item.mode == mseg_pkg::MODE_DEST)
                     && (int'(r_item.segment) <= SEGMENTS));

    always_ff @(posedge i_clk) begin
        if (we_rate) rate_mem[waddr] <= wdata;
        if (we_dest) dest_mem[waddr] <= wdata;
        r_rate <= rate_mem[raddr];
        r_dest <= dest_mem[raddr];
    end

    // shared multiplier, round half up in Q1.22
    assign diff   = 27'(r_dest) - 27'(r_st);
    assign cv_abs = r_cv[23] ? -27'(r_cv) : 27'(r_cv);

    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (i_cmd.mul)
            mseg_pkg::MUL_DIFF_X: begin
                op_a = diff;
                op_b = 27'(r_x);
            end
            mseg_pkg::MUL_DIFF_CV: begin
                op_a = diff;
                op_b = 27'(r_cv);
            end
            mseg_pkg::MUL_DIFF_1MY: begin
                op_a = diff;
                op_b = ONE27 - 27'(r_y);
            end
            mseg_pkg::MUL_Y_1MR: begin
                op_a = 27'(r_y);
                op_b = ONE27 - 27'(r_rate);
            end
            mseg_pkg::MUL_HARD_LVL: begin
                op_a = ONE27 - $signed({4'b0, r_item.retrigger_hardness});
                op_b = 27'(r_lvl);
            end
            mseg_pkg::MUL_C_AM: begin
                op_a = 27'(r_curve);
                op_b = cv_abs - ONE27;
            end
            mseg_pkg::MUL_CV_U: begin
                op_a = 27'(r_cv);
                op_b = r_u;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod = op_a * op_b + 54'sd2097152;

    // common results
    assign st34     = 34'(r_st);
    assign lvl_prod = mseg_pkg::sat24(st34 + 34'(r_prod));
    assign lvl_dest = mseg_pkg::sat24(st34 + 34'(diff));
    assign x_next   = mseg_pkg::sat24(34'(r_x) + 34'(r_rate));

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) r_item <= i_data;
        if (i_cmd.mul != mseg_pkg::MUL_NONE) r_prod <= prod[53:22];
        unique case (i_cmd.act)
            mseg_pkg::ACT_LOAD: begin
                r_x    <= r_px[vi];
                r_y    <= r_fy[vi];
                r_st   <= r_sl[vi];
                r_lvl  <= r_lv[vi];
                r_kind <= r_kn[vi];
                r_seg  <= r_si[vi];
                r_fol  <= r_sf[vi];
            end
            mseg_pkg::ACT_LIN_DONE: begin
                r_lvl <= lvl_prod;
                r_x   <= x_next;
            end
            mseg_pkg::ACT_LIN_END: begin
                r_x       <= mseg_pkg::Q_ONE;
                r_lvl     <= lvl_dest;
                r_ent_st  <= lvl_dest;
                r_ent_seg <= r_fol;
            end
            mseg_pkg::ACT_SETTLE: begin
                r_lvl     <= lvl_dest;
                r_ent_st  <= lvl_dest;
                r_ent_seg <= r_fol;
            end
            mseg_pkg::ACT_DEC_LVL:   r_lvl <= lvl_prod;
            mseg_pkg::ACT_DEC_Y:     r_y   <= mseg_pkg::sat24(34'(r_prod));
            mseg_pkg::ACT_CURV_INIT: r_cv  <= r_x;
            mseg_pkg::ACT_CURV_U:    r_u   <= ONE27 + r_prod[26:0];
            mseg_pkg::ACT_CURV_V:    r_cv  <= mseg_pkg::sat24(34'(r_prod));
            mseg_pkg::ACT_CURV_DONE: begin
                r_y   <= r_cv;
                r_lvl <= lvl_prod;
                r_x   <= x_next;
            end
            mseg_pkg::ACT_STOP: begin
                r_ent_seg <= clamp_seg(r_stop_seg);
                r_ent_st  <= r_lvl;
            end
            mseg_pkg::ACT_START: begin
                r_ent_seg <= clamp_seg(r_start_seg);
                r_ent_st  <= mseg_pkg::sat24(34'(r_prod));
            end
            mseg_pkg::ACT_ENT_SET: begin
                r_x    <= r_rate;
                r_y    <= mseg_pkg::sat24(34'(ONE27) - 34'(r_rate));
                r_st   <= r_ent_st;
                r_kind <= mseg_pkg::kind_of(r_kinds, r_ent_seg, SEGMENTS);
                r_seg  <= r_ent_seg;
                r_fol  <= mseg_pkg::link_of(r_links, r_ent_seg, SEGMENTS);
            end
            default: ;
        endcase
    end

    assign out_free = !r_ovalid || !i_stall;

    // configuration, per-voice write-back, clear counter, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kinds     <= 12'd2187;
            r_links     <= 12'd282;
            r_start_seg <= 3'd1;
            r_stop_seg  <= 3'd4;
            r_floor     <= 23'd1;
            r_curve     <= '0;
            r_clr       <= '0;
            r_ovalid    <= 1'b0;
            for (int i = 0; i < VOICES; i++) begin
                r_px[i] <= '0;
                r_fy[i] <= '0;
                r_sl[i] <= '0;
                r_lv[i] <= '0;
                r_kn[i] <= mseg_pkg::KIND_IDLE;
                r_si[i] <= '0;
                r_sf[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    mseg_pkg::CFG_KINDS: r_kinds     <= i_cfg_data[11:0];
                    mseg_pkg::CFG_LINKS: r_links     <= i_cfg_data[11:0];
                    mseg_pkg::CFG_START: r_start_seg <= i_cfg_data[2:0];
                    mseg_pkg::CFG_STOP:  r_stop_seg  <= i_cfg_data[2:0];
                    mseg_pkg::CFG_FLOOR: r_floor     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.clr) r_clr <= r_clr + 1'b1;
            if (i_cmd.act == mseg_pkg::ACT_START) r_curve <= r_item.attack_curve;
            if ((i_cmd.act == mseg_pkg::ACT_COMMIT) && v_ok) begin
                r_px[vi] <= r_x;
                r_fy[vi] <= r_y;
                r_sl[vi] <= r_st;
                r_lv[vi] <= r_lvl;
                r_kn[vi] <= r_kind;
                r_si[vi] <= r_seg;
                r_sf[vi] <= r_fol;
            end
            if (i_cmd.act == mseg_pkg::ACT_COMMIT) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.act == mseg_pkg::ACT_COMMIT) begin
            r_out.voice_out <= r_item.voice;
            if (v_ok) begin
                r_out.signal      <= r_lvl;
                r_out.segment_now <= r_seg;
                r_out.idle        <= (r_kind == mseg_pkg::KIND_IDLE);
            end else begin
                r_out.signal      <= '0;
                r_out.segment_now <= '0;
                r_out.idle        <= 1'b1;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    // status to the sequencer
    assign o_sts.mode       = r_item.mode;
    assign o_sts.v_ok       = v_ok;
    assign o_sts.kind       = r_kind;
    assign o_sts.x_lt_one   = r_x < mseg_pkg::Q_ONE;
    assign o_sts.y_gt_floor = 25'(r_y) > $signed({2'b0, r_floor});
    assign o_sts.clr_done   = (r_clr == AW'(DEPTH - 1));
    assign o_sts.out_free   = out_free;

endmodule
